[design/satrk_pkg.sv]
package satrk_pkg;
  localparam int PEND_DEPTH_DEF = 32;
  localparam int SEQW = 32;
  localparam int FLGW = 8;
  localparam int RTTW = 48;
  localparam int MASKW = 32;
  localparam logic [RTTW-1:0] RTT_MAX = {RTTW{1'b1}};
endpackage

[design/satrk_div.sv]
module satrk_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [47:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);
  logic [47:0] q;
  logic [32:0] rem;
  logic [5:0]  cnt;
  logic        run;
  logic [32:0] trial;

  // one quotient bit per cycle, restoring
  assign trial = {rem[31:0], q[47]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        q   <= num;
        rem <= '0;
        cnt <= 6'd47;
      end else if (run) begin
        if (!trial[32]) begin
          rem <= trial;
          q   <= {q[46:0], 1'b1};
        end else begin
          rem <= {rem[31:0], q[47]};
          q   <= {q[46:0], 1'b0};
        end
        if (cnt == 6'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

  // saturate the 48-bit quotient to 32 bits
  assign quo = (q[47:32] != '0) ? 32'hFFFF_FFFF : q[31:0];
endmodule

[design/sequence_ack_bitfield_tracker_top.sv]
// Sequence/ack bitfield tracker for one peer.
// Input: pulse start with kind and payload while busy is low; the beat is
// taken on that edge. kind 0 = send, kind 1 = receive.
// Output: one result beat per item, marked by done for exactly one cycle.
// The receiver cannot stall; results are never held off.
// Steps: a send into a non-full buffer appends the entry (S_APPEND) and
// finishes (S_FINISH); a send into a full buffer first shifts every
// entry down by one, each with a read state and a write state
// (S_SHIFT_RD, S_SHIFT_WR), drops the oldest, then appends. A receive
// scans the unacked entries newest first (read, check), runs the serial
// 48-bit divide for each retired entry, then compacts the survivors
// oldest first (read, check each) before it finishes.
// busy stays high from acceptance until the done beat; a new item can be
// taken in the done cycle, and not before it.
// Reset: sequence, mask, counts and RTT totals clear; the unacked buffer
// contents are undefined but never read beyond the fill count.
module sequence_ack_bitfield_tracker_top #(
  parameter int PEND_DEPTH = satrk_pkg::PEND_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [31:0] now_ms,
  input  logic [7:0]  send_flags,
  input  logic [31:0] seq_in,
  input  logic [31:0] ack_in,
  input  logic [31:0] ack_mask_in,
  output logic        done,
  output logic [31:0] seq_out,
  output logic [31:0] ack_seq_out,
  output logic [31:0] ack_mask_out,
  output logic        dropped,
  output logic [31:0] dropped_seq,
  output logic [7:0]  dropped_flags,
  output logic [5:0]  retired_count,
  output logic [31:0] avg_rtt
);
  localparam int AW = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
  localparam int CW = $clog2(PEND_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(PEND_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_SHIFT_RD, S_SHIFT_WR, S_APPEND, S_SCAN_RD, S_SCAN_CHK,
    S_DIV, S_FINISH
  } state_t;

  state_t state;

  // unacked buffer: one write port, one registered read port
  logic [31:0] mem_seq  [PEND_DEPTH];
  logic [31:0] mem_time [PEND_DEPTH];
  logic [7:0]  mem_flg  [PEND_DEPTH];
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [31:0]   wr_seq, wr_time, rd_seq, rd_time;
  logic [7:0]    wr_flg, rd_flg;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_seq[wr_addr]  <= wr_seq;
      mem_time[wr_addr] <= wr_time;
      mem_flg[wr_addr]  <= wr_flg;
    end
    rd_seq  <= mem_seq[rd_addr];
    rd_time <= mem_time[rd_addr];
    rd_flg  <= mem_flg[rd_addr];
  end

  logic [31:0] local_seq, remote_seq, remote_mask;
  logic [CW-1:0] pend_count;
  logic [47:0] rtt_total;
  logic [31:0] acked_total, rtt_average;

  // latched item
  logic        k_kind;
  logic [31:0] k_now, k_ack, k_amask;
  logic [7:0]  k_flags;

  // scan pointers: idx reads (counts down), kept tracks kept entries
  logic [CW-1:0] idx, sh;
  logic [CW-1:0] kept;      // entries kept so far (from address zero)
  logic [5:0]    retired;

  // pass 1 marks removals newest first; compaction pass then copies down
  logic [PEND_DEPTH-1:0] rm_bits;
  logic                  compact;

  logic [31:0] diff, back, cov_d;
  logic        cov_hit;
  logic [31:0] new_mask;
  logic [31:0] new_rseq;

  assign diff = seq_in - remote_seq;
  assign back = remote_seq - seq_in;
  always_comb begin
    new_mask = remote_mask;
    new_rseq = remote_seq;
    if (diff >= 32'd1 && diff <= 32'd32) begin
      new_mask = ((remote_mask << 1) | 32'd1) << (diff - 32'd1);
      new_rseq = seq_in;
    end else if (diff >= 32'hFFFF_FFE0) begin
      new_mask = remote_mask | (32'd1 << back[4:0] - 5'd1);
    end else if (diff > 32'd32 && diff < 32'h8000_0000) begin
      new_mask = '0;
      new_rseq = seq_in;
    end
  end

  assign cov_d   = k_ack - rd_seq;
  assign cov_hit = (cov_d == 32'd0) ||
                   (cov_d <= 32'd32 && k_amask[5'(cov_d - 32'd1)]);

  logic        div_go, div_done;
  logic [31:0] div_quo;
  logic [48:0] tot_sum;
  logic [31:0] sample;
  assign sample  = k_now - rd_time;
  // one carry bit above the total so saturation can be seen
  assign tot_sum = {1'b0, rtt_total} + 49'(sample);

  satrk_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (rtt_total),
    .den  (acked_total),
    .done (div_done),
    .quo  (div_quo)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      local_seq   <= '0;
      remote_seq  <= '0;
      remote_mask <= '0;
      pend_count  <= '0;
      rtt_total   <= '0;
      acked_total <= '0;
      rtt_average <= '0;
      done        <= 1'b0;
      wr_en       <= 1'b0;
      div_go      <= 1'b0;
      compact     <= 1'b0;
    end else begin
      done   <= 1'b0;
      wr_en  <= 1'b0;
      div_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            k_kind  <= kind;
            k_now   <= now_ms;
            k_flags <= send_flags;
            k_ack   <= ack_in;
            k_amask <= ack_mask_in;
            dropped       <= 1'b0;
            dropped_seq   <= '0;
            dropped_flags <= '0;
            retired       <= '0;
            if (!kind) begin
              local_seq <= local_seq + 32'd1;
              if (pend_count >= FULL) begin
                rd_addr <= '0;
                sh      <= '0;
                state   <= S_SHIFT_RD;
              end else begin
                state <= S_APPEND;
              end
            end else begin
              remote_seq  <= new_rseq;
              remote_mask <= new_mask;
              rm_bits     <= '0;
              compact     <= 1'b0;
              if (pend_count == '0) begin
                state <= S_FINISH;
              end else begin
                idx     <= pend_count - CW'(1);
                rd_addr <= AW'(pend_count - CW'(1));
                state   <= S_SCAN_RD;
              end
            end
          end
        end
        // drop the oldest entry: shift entries down by one
        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          if (sh == '0) begin
            dropped       <= 1'b1;
            dropped_seq   <= rd_seq;
            dropped_flags <= rd_flg;
          end else begin
            wr_en   <= 1'b1;
            wr_addr <= AW'(sh - CW'(1));
            wr_seq  <= rd_seq;
            wr_time <= rd_time;
            wr_flg  <= rd_flg;
          end
          if (sh == FULL - CW'(1)) begin
            pend_count <= FULL - CW'(1);
            state      <= S_APPEND;
          end else begin
            sh      <= sh + CW'(1);
            rd_addr <= AW'(sh + CW'(1));
            state   <= S_SHIFT_RD;
          end
        end
        S_APPEND: begin
          if (!wr_en) begin
            wr_en      <= 1'b1;
            wr_addr    <= AW'(pend_count);
            wr_seq     <= local_seq;
            wr_time    <= k_now;
            wr_flg     <= k_flags;
            pend_count <= pend_count + CW'(1);
            state      <= S_FINISH;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (!compact) begin
            // pass one: find covered entries, newest first
            if (cov_hit) begin
              rm_bits[AW'(idx)] <= 1'b1;
              retired     <= retired + 6'd1;
              rtt_total   <= tot_sum[48] ? satrk_pkg::RTT_MAX : tot_sum[47:0];
              if (acked_total != 32'hFFFF_FFFF)
                acked_total <= acked_total + 32'd1;
              div_go <= 1'b1;
              state  <= S_DIV;
            end else begin
              state <= S_SCAN_RD;
            end
            if (idx == '0) begin
              compact <= 1'b1;
              sh      <= '0;
              kept    <= '0;
              rd_addr <= '0;
              if (!cov_hit) state <= S_SCAN_RD;
            end else begin
              idx     <= idx - CW'(1);
              rd_addr <= AW'(idx - CW'(1));
            end
          end else begin
            // pass two: copy survivors down, oldest first
            if (!rm_bits[AW'(sh)]) begin
              wr_en   <= 1'b1;
              wr_addr <= AW'(kept);
              wr_seq  <= rd_seq;
              wr_time <= rd_time;
              wr_flg  <= rd_flg;
              kept    <= kept + CW'(1);
            end
            if (sh == pend_count - CW'(1)) begin
              pend_count <= kept + CW'(!rm_bits[AW'(sh)]);
              state      <= S_FINISH;
            end else begin
              sh      <= sh + CW'(1);
              rd_addr <= AW'(sh + CW'(1));
              state   <= S_SCAN_RD;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            rtt_average <= div_quo;
            state       <= S_SCAN_RD;
          end
        end
        S_FINISH: begin
          done          <= 1'b1;
          seq_out       <= k_kind ? 32'd0 : local_seq;
          ack_seq_out   <= remote_seq;
          ack_mask_out  <= remote_mask;
          retired_count <= retired;
          avg_rtt       <= rtt_average;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fill: assert property (@(posedge clk) disable iff (rst)
    pend_count <= FULL) else $error("fill count beyond depth");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accept did not raise busy");
  a_no_drop_rx: assert property (@(posedge clk) disable iff (rst)
    (done && k_kind) |-> !dropped)
    else $error("drop on receive");
endmodule
